// File: hdl/utf8_codepoint_decoder_assert.svh
// Assertion macros for the UTF-8 code point decoder.
// Used by modules that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef UTF8_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_CODEPOINT_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only outside reset
`define U8D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// Checked on every edge, reset included
`define U8D_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define U8D_ASSERT(lbl, prop, msg)
`define U8D_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: hdl/u8d_pkg.sv
// Shared types and constants of the UTF-8 code point decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    // Replacement character U+FFFD
    localparam logic [20:0] C_REPLACEMENT = 21'h00FFFD;
    // Default depth of the queue between front and back
    localparam int C_QUEUE_DEPTH = 4;
    // Decode window: up to three held bytes plus one new byte
    localparam int C_WIN_DEPTH = 4;

    // Classification masks and patterns
    localparam logic [7:0] C_MASK_2  = 8'hE0;
    localparam logic [7:0] C_LEAD_2  = 8'hC0;
    localparam logic [7:0] C_MASK_3  = 8'hF0;
    localparam logic [7:0] C_LEAD_3  = 8'hE0;
    localparam logic [7:0] C_MASK_4  = 8'hF8;
    localparam logic [7:0] C_LEAD_4  = 8'hF0;
    localparam logic [7:0] C_MASK_CT = 8'hC0;
    localparam logic [7:0] C_CONT    = 8'h80;

    // Sequence length codes: zero marks a byte that cannot start a sequence
    localparam logic [2:0] C_LEN_BAD = 3'd0;
    localparam logic [2:0] C_LEN_1   = 3'd1;
    localparam logic [2:0] C_LEN_2   = 3'd2;
    localparam logic [2:0] C_LEN_3   = 3'd3;
    localparam logic [2:0] C_LEN_4   = 3'd4;

    // One classified byte
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] len;
        logic       cont;
    } t_byte_info;

    // One queue entry: classified byte plus end-of-text flag
    typedef struct packed {
        t_byte_info info;
        logic       last;
    } t_q_entry;

endpackage

`default_nettype wire

// File: hdl/u8d_front.sv
// Front stage: accepts text bytes, classifies them and pushes them into the queue.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_text_byte,
    input  wire logic              i_end_of_text,
    input  wire logic              i_q_full,
    output logic                   o_q_push,
    output u8d_pkg::t_q_entry      o_q_data
);

    logic                  r_valid;
    logic                  n_valid;
    u8d_pkg::t_q_entry     r_entry;
    u8d_pkg::t_q_entry     n_entry;
    logic                  w_accept;

    // Handshake
    assign o_stall  = r_valid && i_q_full;
    assign w_accept = i_valid && !o_stall;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_data = r_entry;

    // Classify the incoming byte
    always_comb begin
        n_entry.info.data = i_text_byte;
        n_entry.last      = i_end_of_text;
        n_entry.info.cont = (i_text_byte & u8d_pkg::C_MASK_CT) == u8d_pkg::C_CONT;
        priority if (!i_text_byte[7]) begin
            n_entry.info.len = u8d_pkg::C_LEN_1;
        end else if ((i_text_byte & u8d_pkg::C_MASK_2) == u8d_pkg::C_LEAD_2) begin
            n_entry.info.len = u8d_pkg::C_LEN_2;
        end else if ((i_text_byte & u8d_pkg::C_MASK_3) == u8d_pkg::C_LEAD_3) begin
            n_entry.info.len = u8d_pkg::C_LEN_3;
        end else if ((i_text_byte & u8d_pkg::C_MASK_4) == u8d_pkg::C_LEAD_4) begin
            n_entry.info.len = u8d_pkg::C_LEN_4;
        end else begin
            n_entry.info.len = u8d_pkg::C_LEN_BAD;
        end
    end

    // Stage occupancy
    always_comb begin
        priority if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_entry <= n_entry;
        end
    end

endmodule

`default_nettype wire

// File: hdl/u8d_queue.sv
// Short register queue between the front and back stages of the decoder.
// Depends on u8d_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module u8d_queue #(
    parameter int DEPTH = u8d_pkg::C_QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire u8d_pkg::t_q_entry i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output u8d_pkg::t_q_entry      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    u8d_pkg::t_q_entry r_mem [DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [CW-1:0]     r_cnt;
    logic [AW-1:0]     n_wr;
    logic [AW-1:0]     n_rd;
    logic [CW-1:0]     n_cnt;

    assign o_full  = r_cnt == FULL_CNT;
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];

    // Pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/u8d_back.sv
// Back stage: decode window over held bytes, one result per cycle into an output register unless stalled.
// Depends on u8d_pkg and utf8_codepoint_decoder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_codepoint_decoder_assert.svh"

module u8d_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire u8d_pkg::t_q_entry i_q_data,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [20:0]            o_code_point,
    output logic                   o_is_replacement,
    output logic                   o_run_last,
    output logic                   o_text_done
);

    localparam int WIN = u8d_pkg::C_WIN_DEPTH;
    localparam int IW  = $clog2(WIN);

    // Window state
    u8d_pkg::t_byte_info r_buf [WIN];
    u8d_pkg::t_byte_info n_buf [WIN];
    logic [2:0]          r_cnt;
    logic [2:0]          n_cnt;
    logic                r_busy;
    logic                r_last;

    // Output register
    logic                r_ovalid;
    logic                n_ovalid;
    logic [20:0]         r_cp;
    logic                r_repl;
    logic                r_run_last;
    logic                r_text_done;

    // Working signals
    u8d_pkg::t_byte_info w_buf [WIN];
    logic [2:0]          w_cnt;
    logic                w_last;
    logic                w_out_free;
    logic                w_go;
    logic                w_bad;
    logic                w_emit;
    logic [2:0]          w_shift;
    logic [20:0]         w_cp;
    logic                w_repl;
    logic                w_bad2;
    logic                w_more;

    assign w_out_free = !r_ovalid || !i_stall;
    assign w_go       = (r_busy || i_q_valid) && w_out_free;
    assign o_q_pop    = !r_busy && i_q_valid && w_out_free;

    // Window: held bytes with the new byte appended when starting an item
    always_comb begin
        w_last = r_busy ? r_last : i_q_data.last;
        w_cnt  = r_busy ? r_cnt : r_cnt + 3'd1;
        for (int i = 0; i < WIN; i++) begin
            w_buf[i] = (!r_busy && r_cnt == 3'(i)) ? i_q_data.info : r_buf[i];
        end
    end

    // Continuation check on the bytes of the leading sequence that are present
    always_comb begin
        w_bad = 1'b0;
        for (int j = 1; j < WIN; j++) begin
            if (3'(j) < w_buf[0].len && 3'(j) < w_cnt && !w_buf[j].cont) begin
                w_bad = 1'b1;
            end
        end
    end

    // Decode the sequence at the head of the window
    always_comb begin
        w_emit  = 1'b0;
        w_shift = 3'd0;
        w_cp    = u8d_pkg::C_REPLACEMENT;
        w_repl  = 1'b1;
        priority if (w_buf[0].len == u8d_pkg::C_LEN_1) begin
            w_emit  = 1'b1;
            w_shift = 3'd1;
            w_cp    = {13'd0, w_buf[0].data};
            w_repl  = 1'b0;
        end else if (w_buf[0].len == u8d_pkg::C_LEN_BAD || w_bad) begin
            w_emit  = 1'b1;
            w_shift = 3'd1;
        end else if (w_cnt >= w_buf[0].len) begin
            w_emit  = 1'b1;
            w_shift = w_buf[0].len;
            w_repl  = 1'b0;
            unique case (w_buf[0].len)
                u8d_pkg::C_LEN_2: w_cp = {10'd0, w_buf[0].data[4:0], w_buf[1].data[5:0]};
                u8d_pkg::C_LEN_3: w_cp = {5'd0, w_buf[0].data[3:0], w_buf[1].data[5:0],
                                          w_buf[2].data[5:0]};
                default:          w_cp = {w_buf[0].data[2:0], w_buf[1].data[5:0],
                                          w_buf[2].data[5:0], w_buf[3].data[5:0]};
            endcase
        end else if (w_last) begin
            // text ends inside a sequence
            w_emit  = 1'b1;
            w_shift = 3'd1;
        end else begin
            // incomplete sequence: hold it
            w_emit  = 1'b0;
            w_shift = 3'd0;
        end
    end

    // Window after consuming the head sequence
    always_comb begin
        logic [2:0] idx;
        n_cnt = w_cnt - w_shift;
        for (int i = 0; i < WIN; i++) begin
            idx = 3'(i) + w_shift;
            n_buf[i] = (idx < 3'(WIN)) ? w_buf[idx[IW-1:0]] : w_buf[i];
        end
    end

    // Look ahead: does the remaining window give another result for this item
    always_comb begin
        w_bad2 = 1'b0;
        for (int j = 1; j < WIN; j++) begin
            if (3'(j) < n_buf[0].len && 3'(j) < n_cnt && !n_buf[j].cont) begin
                w_bad2 = 1'b1;
            end
        end
        w_more = w_emit && (n_cnt != 3'd0)
              && (n_buf[0].len <= u8d_pkg::C_LEN_1 || w_bad2
                  || n_cnt >= n_buf[0].len || w_last);
    end

    // Output register occupancy
    always_comb begin
        priority if (w_go && w_emit) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 3'd0;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            if (w_go) begin
                r_cnt  <= n_cnt;
                r_busy <= w_more;
            end
        end
    end

    // Payload state
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_last <= w_last;
            for (int i = 0; i < WIN; i++) begin
                r_buf[i] <= n_buf[i];
            end
        end
        if (w_go && w_emit) begin
            r_cp        <= w_cp;
            r_repl      <= w_repl;
            r_run_last  <= !w_more;
            r_text_done <= !w_more && w_last;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_code_point     = r_cp;
    assign o_is_replacement = r_repl;
    assign o_run_last       = r_run_last;
    assign o_text_done      = r_text_done;

    // Checks
    `U8D_ASSERT_RST(a_reset_clears, !i_rst_n |=> (!r_busy && !r_ovalid && r_cnt == 3'd0), "reset did not clear decoder state")
    `U8D_ASSERT(a_held_limit, !r_busy |-> (r_cnt <= 3'd3), "more than three bytes held between items")
    `U8D_ASSERT(a_busy_nonempty, r_busy |-> (r_cnt != 3'd0), "busy with an empty window")
    `U8D_ASSERT(a_text_end_flush, (w_go && !w_more && w_last) |=> (r_cnt == 3'd0), "bytes left after end of text")
    `U8D_ASSERT(a_done_is_run_last, (r_ovalid && r_text_done) |-> r_run_last, "text done without run last")

endmodule

`default_nettype wire

// File: hdl/utf8_codepoint_decoder.sv
// UTF-8 decoder: one byte per cycle while o_stall is low, into U+FFFD-substituting code points.
// An accepted byte passes the front register and the queue before its first result is written to the output register.
// Throughput: one result per cycle while i_stall is low; a byte causes 1 to 4 results, or none
// when it only extends a held sequence, and the next byte is popped after its last result.
// Reset: synchronous, active low; clears held bytes count, queue and output valid.
// Depends on u8d_pkg, u8d_front, u8d_queue, u8d_back.
`timescale 1ns / 1ps
`default_nettype none

module utf8_codepoint_decoder #(
    parameter int QUEUE_DEPTH = u8d_pkg::C_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [20:0]      o_code_point,
    output logic             o_is_replacement,
    output logic             o_run_last,
    output logic             o_text_done
);

    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_q_valid;
    u8d_pkg::t_q_entry w_push_data;
    u8d_pkg::t_q_entry w_pop_data;

    u8d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_q_full      (w_full),
        .o_q_push      (w_push),
        .o_q_data      (w_push_data)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_pop_data)
    );

    u8d_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_q_valid),
        .i_q_data         (w_pop_data),
        .o_q_pop          (w_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_code_point     (o_code_point),
        .o_is_replacement (o_is_replacement),
        .o_run_last       (o_run_last),
        .o_text_done      (o_text_done)
    );

endmodule

`default_nettype wire
